// ----- rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// Marker block extractor package
// Shared types, marker tables and codes for the marker block extractor.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // Header field limits and the counter widths that follow from them.
    localparam int PATH_CHARS = 63;
    localparam int TYPE_CHARS = 5;
    localparam int PATH_W     = $clog2(PATH_CHARS + 1);
    localparam int TYPE_W     = $clog2(TYPE_CHARS + 1);

    // Marker lengths.
    localparam logic [2:0] START_LEN = 3'd6;
    localparam logic [2:0] END_LEN   = 3'd7;

    // Delimiter characters.
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Result class codes.
    localparam logic [2:0] CLS_TEXT         = 3'd0;
    localparam logic [2:0] CLS_PAYLOAD      = 3'd1;
    localparam logic [2:0] CLS_PAYLOAD_ONLY = 3'd2;
    localparam logic [2:0] CLS_PATH         = 3'd3;
    localparam logic [2:0] CLS_TYPE         = 3'd4;
    localparam logic [2:0] CLS_DONE         = 3'd5;

    // Input command codes.
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Parser modes; unused codes behave as text mode.
    typedef enum logic [2:0] {
        MODE_TEXT    = 3'd0,
        MODE_PATH    = 3'd1,
        MODE_TYPE    = 3'd2,
        MODE_SKIP    = 3'd3,
        MODE_PAYLOAD = 3'd4
    } t_mode;

    // Controller states.
    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EVAL,
        CTL_REPLAY,
        CTL_TAIL
    } t_ctl_state;

    // Input and output words.
    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] out_class;
        logic       last;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic eval;
        logic step;
        logic sel_tail;
        logic last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic plan_replay;
        logic plan_tail;
        logic replay_last;
        logic tail_en;
    } t_dp_status;

    // Start marker "<<A2W ".
    function automatic logic [7:0] start_mark_at(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_LT;
            3'd1:    c = CH_LT;
            3'd2:    c = 8'h41;
            3'd3:    c = 8'h32;
            3'd4:    c = 8'h57;
            3'd5:    c = CH_SPACE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // End marker "<<A2E>>".
    function automatic logic [7:0] end_mark_at(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_LT;
            3'd1:    c = CH_LT;
            3'd2:    c = 8'h41;
            3'd3:    c = 8'h32;
            3'd4:    c = 8'h45;
            3'd5:    c = CH_GT;
            3'd6:    c = CH_GT;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/mbe_datapath.sv -----
// ----------------------------------------------------------------------------
// Marker block extractor datapath
// Holds the parser state and the captured word, works out the update and
// the output plan for one word, and forms each output word.
// ----------------------------------------------------------------------------
module mbe_datapath import mbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_word   i_in_word,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_word  o_out_word
);

    // Captured input word.
    t_in_word          r_item;

    // Parser state.
    t_mode             r_mode, n_mode;
    logic [2:0]        r_start_m, n_start_m;
    logic [2:0]        r_end_m, n_end_m;
    logic [PATH_W-1:0] r_path_len, n_path_len;
    logic [TYPE_W-1:0] r_type_len, n_type_len;
    logic              r_block_seen, n_block_seen;

    // Output plan: replayed marker bytes, then an optional tail byte.
    logic [2:0]        r_rep_n, n_rep_n;
    logic              r_rep_end, n_rep_end;
    logic              r_tail_en, n_tail_en;
    logic [2:0]        r_tail_cls, n_tail_cls;
    logic [2:0]        r_idx;

    // Match positions after wrapping a full match back to zero.
    logic [2:0]        sm, em;

    assign sm = (r_start_m >= START_LEN) ? 3'd0 : r_start_m;
    assign em = (r_end_m >= END_LEN) ? 3'd0 : r_end_m;

    // Capture the accepted word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_word;
        end
    end

    // Next parser state and output plan for the captured word.
    always_comb begin
        n_mode       = r_mode;
        n_start_m    = r_start_m;
        n_end_m      = r_end_m;
        n_path_len   = r_path_len;
        n_type_len   = r_type_len;
        n_block_seen = r_block_seen;
        n_rep_n      = 3'd0;
        n_rep_end    = 1'b0;
        n_tail_en    = 1'b0;
        n_tail_cls   = CLS_TEXT;

        if (r_item.cmd == CMD_RESTART) begin
            n_mode       = MODE_TEXT;
            n_start_m    = 3'd0;
            n_end_m      = 3'd0;
            n_path_len   = '0;
            n_type_len   = '0;
            n_block_seen = 1'b0;
        end else begin
            case (r_mode)
                MODE_PATH: begin
                    if (r_item.ch == CH_SPACE) begin
                        n_mode     = MODE_TYPE;
                        n_type_len = '0;
                    end else if (r_path_len < PATH_W'(PATH_CHARS)) begin
                        n_path_len = r_path_len + 1'b1;
                        n_tail_en  = 1'b1;
                        n_tail_cls = CLS_PATH;
                    end
                end
                MODE_TYPE: begin
                    if (r_item.ch == CH_GT) begin
                        n_mode = MODE_SKIP;
                    end else if (r_type_len < TYPE_W'(TYPE_CHARS)) begin
                        n_type_len = r_type_len + 1'b1;
                        n_tail_en  = 1'b1;
                        n_tail_cls = CLS_TYPE;
                    end
                end
                MODE_SKIP: begin
                    n_mode  = MODE_PAYLOAD;
                    n_end_m = 3'd0;
                end
                MODE_PAYLOAD: begin
                    if (r_item.ch == end_mark_at(em)) begin
                        if (em == END_LEN - 3'd1) begin
                            n_block_seen = 1'b1;
                            n_mode       = MODE_TEXT;
                            n_end_m      = 3'd0;
                            n_start_m    = 3'd0;
                            n_tail_en    = 1'b1;
                            n_tail_cls   = CLS_DONE;
                        end else begin
                            n_end_m = em + 3'd1;
                        end
                    end else begin
                        // Broken end marker: its bytes go out as payload only.
                        n_rep_n   = em;
                        n_rep_end = 1'b1;
                        if (em != 3'd0 && r_item.ch == CH_LT) begin
                            n_end_m = 3'd1;
                        end else begin
                            n_end_m    = 3'd0;
                            n_tail_en  = 1'b1;
                            n_tail_cls = CLS_PAYLOAD;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_TEXT;
                    if (r_item.ch == start_mark_at(sm)) begin
                        if (sm == START_LEN - 3'd1) begin
                            n_mode     = MODE_PATH;
                            n_path_len = '0;
                            n_start_m  = 3'd0;
                        end else begin
                            n_start_m = sm + 3'd1;
                        end
                    end else begin
                        // Broken start marker: its bytes go out as text.
                        n_rep_n   = sm;
                        n_rep_end = 1'b0;
                        if (sm != 3'd0 && r_item.ch == CH_LT) begin
                            n_start_m = 3'd1;
                        end else begin
                            n_start_m  = 3'd0;
                            n_tail_en  = 1'b1;
                            n_tail_cls = CLS_TEXT;
                        end
                    end
                end
            endcase
        end
    end

    // Parser state and plan registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_TEXT;
            r_start_m    <= 3'd0;
            r_end_m      <= 3'd0;
            r_path_len   <= '0;
            r_type_len   <= '0;
            r_block_seen <= 1'b0;
            r_rep_n      <= 3'd0;
            r_rep_end    <= 1'b0;
            r_tail_en    <= 1'b0;
            r_tail_cls   <= CLS_TEXT;
            r_idx        <= 3'd0;
        end else if (i_cmd.eval) begin
            r_mode       <= n_mode;
            r_start_m    <= n_start_m;
            r_end_m      <= n_end_m;
            r_path_len   <= n_path_len;
            r_type_len   <= n_type_len;
            r_block_seen <= n_block_seen;
            r_rep_n      <= n_rep_n;
            r_rep_end    <= n_rep_end;
            r_tail_en    <= n_tail_en;
            r_tail_cls   <= n_tail_cls;
            r_idx        <= 3'd0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    // Status towards the controller.
    assign o_status.plan_replay = (n_rep_n != 3'd0);
    assign o_status.plan_tail   = n_tail_en;
    assign o_status.replay_last = (r_idx == r_rep_n - 3'd1);
    assign o_status.tail_en     = r_tail_en;

    // Output word: a replayed marker byte or the tail byte.
    always_comb begin
        if (i_cmd.sel_tail) begin
            o_out_word.out_byte  = r_item.ch;
            o_out_word.out_class = r_tail_cls;
        end else if (r_rep_end) begin
            o_out_word.out_byte  = end_mark_at(r_idx);
            o_out_word.out_class = CLS_PAYLOAD_ONLY;
        end else begin
            o_out_word.out_byte  = start_mark_at(r_idx);
            o_out_word.out_class = CLS_TEXT;
        end
        o_out_word.last = i_cmd.last;
    end

endmodule

// ----- rtl/mbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Marker block extractor controller
// Sequences capture, evaluation and delivery of the output words of one
// input word.
// ----------------------------------------------------------------------------
module mbe_ctrl import mbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_ctl_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CTL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        o_in_stall     = 1'b1;
        o_out_valid    = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.eval     = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.sel_tail = 1'b0;
        o_cmd.last     = 1'b0;

        case (r_state)
            CTL_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = CTL_EVAL;
                end
            end
            CTL_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_status.plan_replay) begin
                    n_state = CTL_REPLAY;
                end else if (i_status.plan_tail) begin
                    n_state = CTL_TAIL;
                end else begin
                    n_state = CTL_IDLE;
                end
            end
            CTL_REPLAY: begin
                o_out_valid = 1'b1;
                o_cmd.last  = i_status.replay_last && !i_status.tail_en;
                if (!i_out_stall) begin
                    o_cmd.step = 1'b1;
                    if (i_status.replay_last) begin
                        n_state = i_status.tail_en ? CTL_TAIL : CTL_IDLE;
                    end
                end
            end
            CTL_TAIL: begin
                o_out_valid    = 1'b1;
                o_cmd.sel_tail = 1'b1;
                o_cmd.last     = 1'b1;
                if (!i_out_stall) begin
                    n_state = CTL_IDLE;
                end
            end
            default: begin
                n_state = CTL_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/marker_block_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// Marker block extractor
// Passes a byte stream through as text and lifts marked blocks out of it,
// tagging path, type and payload bytes and flagging block completion.
//
//   Channel   Signals                                  Word
//   input     i_in_valid, o_in_stall, i_in_word        t_in_word  (cmd, ch)
//   output    o_out_valid, i_out_stall, o_out_word     t_out_word (byte, class, last)
//
// An input word is captured in the idle state and then given a single
// evaluation step, which plans up to 7 output words. The output sequencer
// then delivers one word per cycle while the output is not stalled, and
// the next input word is taken only once the last output word has gone.
// Reset is synchronous and returns the parser to text mode.
// Output stalls hold the current word and delay the next input word.
// ----------------------------------------------------------------------------
module marker_block_extractor_unit import mbe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer.
    mbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Parser state and output formation.
    mbe_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_out_word (o_out_word)
    );

endmodule
